[hdl/i2bd_pkg.sv]
package i2bd_pkg;

	localparam int DATA_W = 64;
	localparam int NDIG   = 5;
	localparam int DIG_W  = 14;
	localparam int CNT_W  = 3;
	localparam int BIT_CW = $clog2(DATA_W);
	localparam int IN_W   = ((DATA_W + 7) / 8) * 8;
	localparam int RES_W  = 1 + 2 * CNT_W + NDIG * DIG_W;
	localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

	typedef logic [DIG_W-1:0] digit_t;

	localparam digit_t RADIX = 14'd10000;
	localparam digit_t HALF  = 14'd5000;

	typedef struct packed {
		logic clr;
		logic shift;
	} cell_ctl_t;

	// lowest bit first: negative, digit_count, weight, digit_a .. digit_e
	typedef struct packed {
		logic [OUT_W-RES_W-1:0]  pad;
		digit_t [NDIG-1:0]       digits;
		logic [CNT_W-1:0]        weight;
		logic [CNT_W-1:0]        count;
		logic                    negative;
	} result_t;

endpackage

[hdl/i2bd_cell.sv]
module i2bd_cell (
	input  logic                clk,
	input  i2bd_pkg::cell_ctl_t ctl,
	input  logic                cin,
	output logic                cout,
	output i2bd_pkg::digit_t    digit
);
	import i2bd_pkg::*;

	digit_t           digit_q;
	logic [DIG_W:0]   dbl;

	// doubling a digit of 5000 or more spills one into the next digit
	assign dbl   = {digit_q, cin};
	assign cout  = (digit_q >= HALF);
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			digit_q <= '0;
		end else if (ctl.shift) begin
			if (cout) begin
				digit_q <= DIG_W'(dbl - {1'b0, RADIX});
			end else begin
				digit_q <= dbl[DIG_W-1:0];
			end
		end
	end

endmodule

[hdl/int_to_base10000_digits.sv]
// Converts a 64-bit word, read as signed or unsigned as s_tuser says, into a sign flag and up
// to five base-10000 digits, most significant first, with the digit count and the weight
// (count minus one, 0 for a zero input). Trailing zero digits are kept; unused digit fields
// are zero. The signed minimum converts correctly with a magnitude of 2^63. For each item the
// word is taken and its magnitude formed, then the magnitude shifts one bit per cycle into a
// chain of five double-and-subtract-10000 base-10000 digit cells, and the result is packed
// into the output register once it is free, so an output waiting on m_tready stalls
// conversion. A new word is taken once the previous result is in the output register.
module int_to_base10000_digits (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [i2bd_pkg::IN_W-1:0]     s_tdata,  // value[63:0]
	input  logic                          s_tuser,  // is_signed
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// negative, digit_count[2:0], weight[2:0], digit_a .. digit_e [13:0] each, zero fill
	output logic [i2bd_pkg::OUT_W-1:0]    m_tdata
);
	import i2bd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [BIT_CW-1:0]    cnt_q;
	logic [DATA_W-1:0]    mag_q;
	logic                 neg_q;
	logic                 m_tvalid_q;
	result_t              res_q;
	result_t              res_d;
	logic                 in_xfer;
	logic                 neg_in;
	cell_ctl_t            ctl;
	logic [NDIG:0]        carry;
	digit_t               dig [NDIG];
	logic [CNT_W-1:0]     cnt_d;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign neg_in   = s_tuser && s_tdata[DATA_W-1];
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q;

	assign ctl.clr   = in_xfer;
	assign ctl.shift = (state_q == ST_RUN);
	assign carry[0]  = mag_q[DATA_W-1];

	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		i2bd_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.cin   (carry[i]),
			.cout  (carry[i+1]),
			.digit (dig[i])
		);
	end

	// cell 0 holds the least significant digit; the output lists the top used digit first
	always_comb begin
		cnt_d = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (dig[i] != '0) begin
				cnt_d = CNT_W'(i + 1);
			end
		end
		res_d          = '0;
		res_d.negative = neg_q;
		res_d.count    = cnt_d;
		res_d.weight   = (cnt_d == '0) ? '0 : cnt_d - 1'b1;
		for (int k = 0; k < NDIG; k++) begin
			if (CNT_W'(k) < cnt_d) begin
				res_d.digits[k] = dig[CNT_W'(cnt_d - CNT_W'(k) - 1'b1)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BIT_CW'(DATA_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			neg_q <= neg_in;
			mag_q <= neg_in ? (~s_tdata[DATA_W-1:0]) + 1'b1 : s_tdata[DATA_W-1:0];
		end else if (state_q == ST_RUN) begin
			mag_q <= {mag_q[DATA_W-2:0], 1'b0};
		end
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			res_q <= res_d;
		end
	end

	// five digits always suffice for 64 bits, so the top cell never spills
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !carry[NDIG])
		else $error("digit chain overflow");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN || state_q == ST_DONE) |->
		(dig[0] < RADIX) && (dig[1] < RADIX) && (dig[2] < RADIX) &&
		(dig[3] < RADIX) && (dig[4] < RADIX))
		else $error("digit out of range");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_RUN) && (cnt_q == '0))
		else $error("conversion did not start");

	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && res_q.count != '0) |-> (res_q.digits[0] != '0))
		else $error("leading digit is zero");

endmodule
